>>> src/cogging_torque_table_compensator_assert.svh
// ----------------------------------------------------------------------------
// Cogging torque compensator assertion macros
// Concurrent assertion wrappers; they compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef COGGING_TORQUE_TABLE_COMPENSATOR_ASSERT_SVH
`define COGGING_TORQUE_TABLE_COMPENSATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Assert on an explicit clock and active-low reset
`define CTC_ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert on the block clock and reset
`define CTC_ASSERT(lbl, prop, msg) `CTC_ASSERT_AT(lbl, i_clk, i_rst_n, prop, msg)
`else
`define CTC_ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define CTC_ASSERT(lbl, prop, msg)
`endif

`endif

>>> src/ctc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cogging torque compensator package
// Widths, constants, codes and state type used by the compensator top module.
// ----------------------------------------------------------------------------
package ctc_pkg;

    localparam int TABLE_ENTRIES       = 360;
    localparam int ANGLE_FRACTION_BITS = 8;
    localparam int ANGLE_W             = 17;
    localparam int TORQUE_W            = 16;
    localparam int CONF_W              = 10;
    localparam int ENTRY_EXTRA_BITS    = 8;
    localparam int ENTRY_W             = TORQUE_W + ENTRY_EXTRA_BITS;
    localparam int IDX_W               = $clog2(TABLE_ENTRIES);
    localparam int IDX_RAW_W           = ANGLE_W - ANGLE_FRACTION_BITS;

    // Exponential average: alpha = 3277 / 2^16
    localparam int ALPHA_Q16   = 3277;
    localparam int ALPHA_SHIFT = 16;

    localparam int CONF_FULL = 1000;
    localparam int CONF_MIN  = 10;

    localparam int FRAC_ONE = 1 << ANGLE_FRACTION_BITS;
    localparam int WEIGHT_W = ANGLE_FRACTION_BITS + 1;
    localparam int DIFF_W   = ENTRY_W + 1;
    localparam int INTERP_W = ENTRY_W + ANGLE_FRACTION_BITS;

    // Scaling: |interp| * conf / (CONF_FULL << SCALE_SHIFT), rounded half up
    localparam int     SCALE_SHIFT = ENTRY_EXTRA_BITS + ANGLE_FRACTION_BITS;
    localparam int     SCALED_W    = INTERP_W + CONF_W;
    localparam longint HALF_DEN    = longint'(CONF_FULL) << (SCALE_SHIFT - 1);
    localparam int     QX_W        = SCALED_W - SCALE_SHIFT;

    // Division by CONF_FULL as a multiply by a rounded-up reciprocal
    localparam int     RECIP_SHIFT = QX_W + $clog2(CONF_FULL);
    localparam longint RECIP       = ((longint'(1) << RECIP_SHIFT) + CONF_FULL - 1) / CONF_FULL;
    localparam int     RECIP_W     = RECIP_SHIFT - $clog2(CONF_FULL) + 1;

    // Shared signed multiplier
    localparam int MUL_A_W = INTERP_W + 1;
    localparam int MUL_B_W = RECIP_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int Q_W     = PROD_W - RECIP_SHIFT;

    localparam logic signed [PROD_W-1:0] ALPHA_HALF = PROD_W'(longint'(1) << (ALPHA_SHIFT - 1));

    localparam int TORQUE_MAX     = 32767;
    localparam int TORQUE_MIN_MAG = 32768;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int DATA_W  = 32;

    typedef enum logic [0:0] {
        REG_COMP_ENABLE = 1'b0
    } t_reg;

    typedef enum logic {
        OP_LEARN      = 1'b0,
        OP_COMPENSATE = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_L_MUL,
        S_L_WR,
        S_C_RD1,
        S_C_MUL1,
        S_C_SUM,
        S_C_MAG,
        S_C_DIV,
        S_C_SAT,
        S_DONE
    } t_state;

endpackage

>>> src/ctc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cogging table RAM
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module ctc_ram #(
    parameter int DEPTH = 360,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/cogging_torque_table_compensator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cogging torque table compensator
// Learns a cogging torque table over one electrical turn and returns the
// negated, confidence-scaled, interpolated torque as a feedforward term.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request: operation,
//   angle and measured torque. A learn request updates one table entry and
//   the confidence count and returns nothing. A compensate request returns
//   one result (torque, confidence) on the output channel
//   (o_out_valid / i_out_stall).
//   Sequencing: a learn request passes through S_L_MUL and S_L_WR. A
//   compensate request steps through S_C_RD1, S_C_MUL1, S_C_SUM, S_C_MAG,
//   S_C_DIV and S_C_SAT to S_DONE; no new request is taken until S_IDLE.
//   When disabled or below minimum confidence the request goes to S_DONE.
//   The sequence is set by the single shared multiplier, used four times per
//   compensate request, and the single-port table RAM, read twice.
//   Reset: the enable register and confidence clear, then a clearing pass
//   writes zero to every table entry; o_in_stall stays high
//   meanwhile. APB writes are taken at any time.
//   Output stall: the result sits in an output register; a finished result
//   waits in the sequencer until that register frees, and new requests are
//   held off by o_in_stall until then.
// ----------------------------------------------------------------------------
`include "cogging_torque_table_compensator_assert.svh"

module cogging_torque_table_compensator
    import ctc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // APB configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready,
    // Request channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_operation,
    input  logic [ANGLE_W-1:0]         i_angle,
    input  logic signed [TORQUE_W-1:0] i_measured_torque,
    // Result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [TORQUE_W-1:0] o_compensation_torque,
    output logic [CONF_W-1:0]          o_confidence_level
);

    // Control state
    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_clr_idx;
    logic                r_enable;
    logic [CONF_W-1:0]   r_conf;
    logic                r_out_valid;

    // Request and datapath registers
    logic [IDX_W-1:0]                r_idx;
    logic [IDX_W-1:0]                r_hi;
    logic [ANGLE_FRACTION_BITS-1:0]  r_frac;
    logic signed [TORQUE_W-1:0]      r_tin;
    logic signed [PROD_W-1:0]        r_prod;
    logic signed [INTERP_W-1:0]      r_acc;
    logic [INTERP_W-1:0]             r_mag;
    logic                            r_neg;
    logic signed [TORQUE_W-1:0]      r_res;
    logic signed [TORQUE_W-1:0]      r_out_torque;
    logic [CONF_W-1:0]               r_out_conf;

    // Combinational
    logic                        w_cfg_wr;
    logic                        w_in_accept;
    logic                        w_out_load;
    logic [IDX_RAW_W-1:0]        w_raw;
    logic [IDX_RAW_W-1:0]        w_wrap;
    logic [IDX_W-1:0]            w_idx;
    logic                        w_ram_we;
    logic                        w_ram_re;
    logic [IDX_W-1:0]            w_ram_addr;
    logic [ENTRY_W-1:0]          w_ram_wdata;
    logic [ENTRY_W-1:0]          w_rdata;
    logic signed [ENTRY_W-1:0]   w_entry;
    logic signed [ENTRY_W-1:0]   w_t20;
    logic signed [DIFF_W-1:0]    w_diff;
    logic signed [PROD_W-1:0]    w_step;
    logic signed [DIFF_W-1:0]    w_new;
    logic signed [INTERP_W:0]    w_sum;
    logic signed [INTERP_W-1:0]  w_interp;
    logic [SCALED_W-1:0]         w_scaled;
    logic [QX_W-1:0]             w_qx;
    logic [Q_W-1:0]              w_q;
    logic [WEIGHT_W-1:0]         w_weight_lo;
    logic signed [MUL_A_W-1:0]   w_mul_a;
    logic signed [MUL_B_W-1:0]   w_mul_b;
    logic signed [PROD_W-1:0]    w_prod;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (t_reg'(paddr[2]))
            REG_COMP_ENABLE: prdata = DATA_W'(r_enable);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (w_cfg_wr && t_reg'(paddr[2]) == REG_COMP_ENABLE) begin
            r_enable <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // Handshakes and index decode
    // ------------------------------------------------------------------
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Index wraps once past the last entry
    assign w_raw  = i_angle[ANGLE_W-1:ANGLE_FRACTION_BITS];
    assign w_wrap = (w_raw >= IDX_RAW_W'(TABLE_ENTRIES)) ?
                    w_raw - IDX_RAW_W'(TABLE_ENTRIES) : w_raw;
    assign w_idx  = IDX_W'(w_wrap);

    // ------------------------------------------------------------------
    // Table RAM
    // ------------------------------------------------------------------
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;
        w_ram_addr  = w_idx;
        w_ram_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_ram_we   = 1'b1;
                w_ram_addr = r_clr_idx;
            end
            S_IDLE: begin
                w_ram_re   = w_in_accept;
                w_ram_addr = w_idx;
            end
            S_C_RD1: begin
                w_ram_re   = 1'b1;
                w_ram_addr = r_hi;
            end
            S_L_WR: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = r_idx;
                w_ram_wdata = w_new[ENTRY_W-1:0];
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    ctc_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_re    (w_ram_re),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_rdata)
    );

    assign w_entry = $signed(w_rdata);

    // ------------------------------------------------------------------
    // Shared multiplier and datapath terms
    // ------------------------------------------------------------------
    assign w_t20       = $signed({r_tin, {ENTRY_EXTRA_BITS{1'b0}}});
    assign w_diff      = DIFF_W'(w_t20) - DIFF_W'(w_entry);
    assign w_step      = (r_prod + ALPHA_HALF) >>> ALPHA_SHIFT;
    assign w_new       = DIFF_W'(w_entry) + w_step[DIFF_W-1:0];
    assign w_weight_lo = WEIGHT_W'(FRAC_ONE) - {1'b0, r_frac};
    assign w_sum       = (INTERP_W + 1)'(r_acc) + (INTERP_W + 1)'($signed(r_prod[INTERP_W-1:0]));
    assign w_interp    = w_sum[INTERP_W-1:0];
    assign w_scaled    = r_prod[SCALED_W-1:0] + SCALED_W'(HALF_DEN);
    assign w_qx        = w_scaled[SCALED_W-1:SCALE_SHIFT];
    assign w_q         = r_prod[PROD_W-1:RECIP_SHIFT];

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_L_MUL: begin
                w_mul_a = MUL_A_W'(w_diff);
                w_mul_b = MUL_B_W'(ALPHA_Q16);
            end
            S_C_RD1: begin
                w_mul_a = MUL_A_W'(w_entry);
                w_mul_b = MUL_B_W'($signed({1'b0, w_weight_lo}));
            end
            S_C_MUL1: begin
                w_mul_a = MUL_A_W'(w_entry);
                w_mul_b = MUL_B_W'($signed({1'b0, r_frac}));
            end
            S_C_MAG: begin
                w_mul_a = $signed({1'b0, r_mag});
                w_mul_b = MUL_B_W'($signed({1'b0, r_conf}));
            end
            S_C_DIV: begin
                w_mul_a = MUL_A_W'($signed({1'b0, w_qx}));
                w_mul_b = $signed({1'b0, RECIP_W'(RECIP)});
            end
            default: begin
                w_mul_a = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_accept) begin
                    if (t_op'(i_operation) == OP_LEARN) begin
                        n_state = S_L_MUL;
                    end else if (r_enable && r_conf >= CONF_W'(CONF_MIN)) begin
                        n_state = S_C_RD1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_L_MUL:  n_state = S_L_WR;
            S_L_WR:   n_state = S_IDLE;
            S_C_RD1:  n_state = S_C_MUL1;
            S_C_MUL1: n_state = S_C_SUM;
            S_C_SUM:  n_state = S_C_MAG;
            S_C_MAG:  n_state = S_C_DIV;
            S_C_DIV:  n_state = S_C_SAT;
            S_C_SAT:  n_state = S_DONE;
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Clear sweep and confidence count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_conf    <= '0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (r_state == S_L_WR && r_conf < CONF_W'(CONF_FULL)) begin
                r_conf <= r_conf + CONF_W'(1);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    r_idx  <= w_idx;
                    r_hi   <= (w_idx == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : w_idx + IDX_W'(1);
                    r_frac <= i_angle[ANGLE_FRACTION_BITS-1:0];
                    r_tin  <= i_measured_torque;
                    r_res  <= '0;
                end
            end
            S_C_MUL1: begin
                r_acc <= $signed(r_prod[INTERP_W-1:0]);
            end
            S_C_SUM: begin
                // Negated result: negative when the interpolated torque is positive
                r_neg <= (w_interp > 0);
                r_mag <= (w_interp < 0) ? INTERP_W'(-w_interp) : INTERP_W'(w_interp);
            end
            S_C_SAT: begin
                if (r_neg) begin
                    r_res <= (w_q > Q_W'(TORQUE_MIN_MAG)) ?
                             TORQUE_W'(-TORQUE_MIN_MAG) : TORQUE_W'(Q_W'(0) - w_q);
                end else begin
                    r_res <= (w_q > Q_W'(TORQUE_MAX)) ?
                             TORQUE_W'(TORQUE_MAX) : TORQUE_W'(w_q);
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_torque <= r_res;
            r_out_conf   <= r_conf;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_compensation_torque = r_out_torque;
    assign o_confidence_level    = r_out_conf;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CTC_ASSERT(a_conf_range, r_conf <= CONF_W'(CONF_FULL), "confidence above full scale")
    `CTC_ASSERT(a_conf_hold, (r_state != S_L_WR) |=> $stable(r_conf), "confidence moved outside learn")
    `CTC_ASSERT(a_idx_range, (r_state != S_CLEAR && r_state != S_IDLE) |-> (r_idx < IDX_W'(TABLE_ENTRIES) && r_hi < IDX_W'(TABLE_ENTRIES)), "table index out of range")
    `CTC_ASSERT(a_learn_path, (w_in_accept && t_op'(i_operation) == OP_LEARN) |=> (r_state == S_L_MUL), "learn request took wrong path")
    `CTC_ASSERT(a_clear_quiet, (r_state == S_CLEAR) |-> !r_out_valid, "result during clearing pass")

endmodule
